[rtl/mtfls_pkg.sv]
`timescale 1ns / 1ps

package mtfls_pkg;

  // List geometry.
  localparam int MAX_ENTRIES = 16;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Fixed field widths of the result item.
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int TOTAL_W  = 5;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2,
    OP_MTF    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_MISSING  = 3'd1,
    ST_APPENDED = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  // Per-cell update control: load takes the broadcast key, shift takes the neighbor.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

[rtl/mtfls_cell.sv]
`timescale 1ns / 1ps

module mtfls_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   capture,
  input  logic                                   valid,
  input  logic signed [mtfls_pkg::VALUE_W-1:0]   key,
  input  logic signed [mtfls_pkg::VALUE_W-1:0]   load_data,
  input  logic signed [mtfls_pkg::VALUE_W-1:0]   prev_data,
  input  mtfls_pkg::cell_ctl_t                   ctl,
  output logic signed [mtfls_pkg::VALUE_W-1:0]   data,
  output logic                                   hit
);
  import mtfls_pkg::*;

  logic signed [VALUE_W-1:0] data_r;
  logic signed [VALUE_W-1:0] data_nxt;
  logic                      hit_r;
  logic                      hit_nxt;

  // Entry update: a write of the key wins over a shift from the neighbor.
  always_comb begin
    priority if (ctl.load) begin
      data_nxt = load_data;
    end else if (ctl.shift) begin
      data_nxt = prev_data;
    end else begin
      data_nxt = data_r;
    end
  end

  // The match flag is sampled when an item is taken in and held for the next cycle.
  assign hit_nxt = capture ? (valid && (data_r == key)) : hit_r;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

[rtl/move_to_front_list_search_unit.sv]
`timescale 1ns / 1ps

// Move-to-front list search unit. At the edge that accepts an item, every cell
// of the list compares its entry with the key at once; in the following cycle
// (busy high) the first match is encoded, the list is updated (append, clear,
// or a one-step shift of the cells ahead of the match with the key written into
// the head) and the result is registered. The result shows on the out_ ports
// with out_strobe for exactly one cycle, in the cycle after the update cycle,
// and must be taken then: there is no way to hold it off. A new item may be
// started in that same cycle, but not while busy is high. Entries are never
// cleared in storage; only those below the entry count take part in a search.
module move_to_front_list_search_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_operation,
  input  logic signed [mtfls_pkg::VALUE_W-1:0]   in_value,
  output logic                                   out_strobe,
  output logic [mtfls_pkg::STATUS_W-1:0]         out_status,
  output logic [mtfls_pkg::POS_W-1:0]            out_position,
  output logic [mtfls_pkg::TOTAL_W-1:0]          out_entry_total
);
  import mtfls_pkg::*;

  logic                       accept;
  logic                       busy_r;
  logic                       busy_nxt;
  op_t                        op_r;
  logic signed [VALUE_W-1:0]  key_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;

  logic [MAX_ENTRIES-1:0]     hit_vec;
  logic signed [VALUE_W-1:0]  cell_data [MAX_ENTRIES];
  cell_ctl_t                  cell_ctl  [MAX_ENTRIES];

  logic [IDX_W-1:0]           hit_idx;
  logic                       found;
  logic                       full;
  status_t                    status_nxt;
  logic [IDX_W+POS_W-1:0]     pos_wide;
  logic [CNT_W+TOTAL_W-1:0]   total_wide;

  logic                       out_strobe_r;
  logic [STATUS_W-1:0]        out_status_r;
  logic [POS_W-1:0]           out_position_r;
  logic [TOTAL_W-1:0]         out_entry_total_r;

  assign accept   = start && !busy_r;
  assign busy_nxt = accept;

  // Key and operation are held for the update cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_operation);
      key_r <= in_value;
    end
  end

  // The row of cells; each one past the head shifts from its lower neighbor.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev;
    if (i == 0) begin : g_head
      assign prev = cell_data[0];
    end else begin : g_body
      assign prev = cell_data[i-1];
    end

    mtfls_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .capture   (accept),
      .valid     (count_r > CNT_W'(i)),
      .key       (in_value),
      .load_data (key_r),
      .prev_data (prev),
      .ctl       (cell_ctl[i]),
      .data      (cell_data[i]),
      .hit       (hit_vec[i])
    );
  end

  // First match from the front.
  always_comb begin
    hit_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign found = |hit_vec;
  assign full  = (count_r == CNT_W'(MAX_ENTRIES));

  // Cell control in the update cycle.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_ctl[i] = '0;
      if (busy_r) begin
        unique case (op_r)
          OP_APPEND: begin
            cell_ctl[i].load = !full && (count_r == CNT_W'(i));
          end
          OP_MTF: begin
            if (found && (hit_idx != '0)) begin
              cell_ctl[i].load  = (i == 0);
              cell_ctl[i].shift = (i != 0) && (IDX_W'(i) <= hit_idx);
            end
          end
          OP_CLEAR, OP_SEARCH: begin
            cell_ctl[i] = '0;
          end
          default: begin
            cell_ctl[i] = '0;
          end
        endcase
      end
    end
  end

  // Result and entry count of the update cycle.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_MISSING;
    pos_wide   = '0;
    unique case (op_r)
      OP_CLEAR: begin
        count_nxt  = '0;
        status_nxt = ST_CLEARED;
      end
      OP_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_APPENDED;
          pos_wide   = (IDX_W+POS_W)'(count_r);
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      OP_SEARCH, OP_MTF: begin
        if (found) begin
          status_nxt = ST_FOUND;
          pos_wide   = (IDX_W+POS_W)'(hit_idx);
        end
      end
      default: begin
        status_nxt = ST_MISSING;
      end
    endcase
  end

  assign total_wide = (CNT_W+TOTAL_W)'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      out_strobe_r <= busy_r;
      if (busy_r) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      out_status_r      <= status_nxt;
      out_position_r    <= pos_wide[POS_W-1:0];
      out_entry_total_r <= total_wide[TOTAL_W-1:0];
    end
  end

  assign busy            = busy_r;
  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_entry_total = out_entry_total_r;

  // An item spends exactly one cycle in the update step.
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r)
    else $error("update step lasted more than one cycle");

  // Every update step yields one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> out_strobe_r)
    else $error("update step without result");

  // The entry count never exceeds the list size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond list size");

  // A clear leaves the list empty.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (op_r == OP_CLEAR)) |=> (count_r == '0))
    else $error("list not empty after clear");

endmodule
